### src/jxmp_pkg.sv
package jxmp_pkg;

    // Parser phases
    typedef enum logic [3:0] {
        PH_SOI0,
        PH_SOI1,
        PH_MK0,
        PH_MK1,
        PH_LEN0,
        PH_LEN1,
        PH_PAY,
        PH_MAIN,
        PH_EXTHDR,
        PH_EXTDATA,
        PH_DONE
    } phase_t;

    // Result kinds
    localparam logic [1:0] KIND_MAIN   = 2'd0;
    localparam logic [1:0] KIND_EXT    = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // Final status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NOT_JPEG   = 3'd1;
    localparam logic [2:0] ST_BAD_LEN    = 3'd2;
    localparam logic [2:0] ST_TRUNCATED  = 3'd3;
    localparam logic [2:0] ST_ZERO_EXT   = 3'd4;
    localparam logic [2:0] ST_OUT_BOUNDS = 3'd5;

    // Marker bytes
    localparam logic [7:0] MK_PREFIX = 8'hFF;
    localparam logic [7:0] MK_SOI    = 8'hD8;
    localparam logic [7:0] MK_SOS    = 8'hDA;
    localparam logic [7:0] MK_APP1   = 8'hE1;

    // Signature lengths, including the closing zero byte
    localparam int SIG_MAIN_LEN = 29;
    localparam int SIG_EXT_LEN  = 35;
    // Extended header: 32-byte GUID, then full length and chunk offset
    localparam int EXT_GUID_LEN = 32;
    localparam int EXT_HDR_LEN  = EXT_GUID_LEN + 8;

    localparam int IDX_W      = 6;
    localparam int REM_W      = 16;
    localparam int CNT_W      = 3;
    localparam int POS_W      = 33;
    localparam logic [IDX_W-1:0] IDX_MAX = '1;

    // Main XMP namespace URI, zero terminated
    localparam logic [7:0] SIG_MAIN [0:SIG_MAIN_LEN-1] = '{
        8'h68, 8'h74, 8'h74, 8'h70, 8'h3A, 8'h2F, 8'h2F, 8'h6E, 8'h73, 8'h2E,
        8'h61, 8'h64, 8'h6F, 8'h62, 8'h65, 8'h2E, 8'h63, 8'h6F, 8'h6D, 8'h2F,
        8'h78, 8'h61, 8'h70, 8'h2F, 8'h31, 8'h2E, 8'h30, 8'h2F, 8'h00
    };

    // Extended XMP namespace URI, zero terminated
    localparam logic [7:0] SIG_EXT [0:SIG_EXT_LEN-1] = '{
        8'h68, 8'h74, 8'h74, 8'h70, 8'h3A, 8'h2F, 8'h2F, 8'h6E, 8'h73, 8'h2E,
        8'h61, 8'h64, 8'h6F, 8'h62, 8'h65, 8'h2E, 8'h63, 8'h6F, 8'h6D, 8'h2F,
        8'h78, 8'h6D, 8'h70, 8'h2F, 8'h65, 8'h78, 8'h74, 8'h65, 8'h6E, 8'h73,
        8'h69, 8'h6F, 8'h6E, 8'h2F, 8'h00
    };

    // Result queue
    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic        segment_start;
        logic [31:0] ext_position;
        logic [31:0] ext_total_length;
        logic [2:0]  status;
        logic        last_result;
    } result_t;

    // Results produced by one byte, in order
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic logic is_payload(input phase_t ph);
        return (ph == PH_PAY) || (ph == PH_MAIN) || (ph == PH_EXTHDR) ||
               (ph == PH_EXTDATA);
    endfunction

    function automatic logic main_mismatch(input logic [IDX_W-1:0] i, input logic [7:0] b);
        logic hit;
        hit = 1'b0;
        if (i < IDX_W'(SIG_MAIN_LEN))
        begin
            hit = (SIG_MAIN[i[4:0]] != b);
        end
        return hit;
    endfunction

    function automatic logic ext_mismatch(input logic [IDX_W-1:0] i, input logic [7:0] b);
        logic hit;
        hit = 1'b0;
        if (i < IDX_W'(SIG_EXT_LEN))
        begin
            hit = (SIG_EXT[i] != b);
        end
        return hit;
    endfunction

endpackage

### src/jxmp_if.sv
interface jxmp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, data_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface jxmp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic        segment_start;
    logic [31:0] ext_position;
    logic [31:0] ext_total_length;
    logic [2:0]  status;
    logic        last_result;

    modport source (output valid, kind, out_byte, segment_start, ext_position,
                    ext_total_length, status, last_result, input ready);
    modport sink   (input valid, kind, out_byte, segment_start, ext_position,
                    ext_total_length, status, last_result, output ready);
endinterface

### src/jxmp_core.sv
module jxmp_core (
    input  logic               clk,
    input  logic               rst_n,
    jxmp_in_if.sink            byte_ch,
    input  logic               room,
    output jxmp_pkg::push_t    push
);

    localparam int IDX_W = jxmp_pkg::IDX_W;
    localparam int REM_W = jxmp_pkg::REM_W;
    localparam int CNT_W = jxmp_pkg::CNT_W;
    localparam int POS_W = jxmp_pkg::POS_W;

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       fire;

    // Parser state
    jxmp_pkg::phase_t   phase_reg, phase_next;
    logic [CNT_W-1:0]   fbc_reg, fbc_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic               app1_reg, app1_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [1:0]         match_reg, match_next;
    logic [31:0]        shift_reg, shift_next;
    logic [31:0]        extlen_reg, extlen_next;
    logic [POS_W-1:0]   chunk_reg, chunk_next;
    logic               seen_reg, seen_next;
    logic               finished_reg, finished_next;
    logic               fault_reg, fault_next;

    // Step results
    logic               data_valid;
    jxmp_pkg::result_t  data_res;
    logic               walk_valid;
    logic [2:0]         walk_code;
    logic [2:0]         stat_code;
    jxmp_pkg::result_t  stat_res;
    logic [REM_W:0]     seg_len;
    logic [1:0]         m;

    assign fire          = in_valid_reg && room;
    assign byte_ch.ready = !in_valid_reg || room;

    // Hold the byte until the result queue has room for its results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (byte_ch.valid && byte_ch.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_ch.valid && byte_ch.ready)
        begin
            in_byte_reg <= byte_ch.data_byte;
            in_last_reg <= byte_ch.last_byte;
        end
    end

    // Parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= jxmp_pkg::PH_SOI0;
            fbc_reg      <= '0;
            rem_reg      <= '0;
            app1_reg     <= 1'b0;
            idx_reg      <= '0;
            match_reg    <= 2'b11;
            shift_reg    <= '0;
            extlen_reg   <= '0;
            chunk_reg    <= '0;
            seen_reg     <= 1'b0;
            finished_reg <= 1'b0;
            fault_reg    <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            fbc_reg      <= fbc_next;
            rem_reg      <= rem_next;
            app1_reg     <= app1_next;
            idx_reg      <= idx_next;
            match_reg    <= match_next;
            shift_reg    <= shift_next;
            extlen_reg   <= extlen_next;
            chunk_reg    <= chunk_next;
            seen_reg     <= seen_next;
            finished_reg <= finished_next;
            fault_reg    <= fault_next;
        end
    end

    // Advance the parser by one byte
    always_comb
    begin
        phase_next    = phase_reg;
        fbc_next      = fbc_reg;
        rem_next      = rem_reg;
        app1_next     = app1_reg;
        idx_next      = idx_reg;
        match_next    = match_reg;
        shift_next    = shift_reg;
        extlen_next   = extlen_reg;
        chunk_next    = chunk_reg;
        seen_next     = seen_reg;
        finished_next = finished_reg;
        fault_next    = fault_reg;
        data_valid    = 1'b0;
        data_res      = '0;
        walk_valid    = 1'b0;
        walk_code     = jxmp_pkg::ST_OK;
        stat_code     = jxmp_pkg::ST_OK;
        seg_len       = {1'b0, rem_reg[REM_W-1:8], in_byte_reg};
        m             = match_reg;

        if (fire)
        begin
            if (fbc_reg < CNT_W'(4))
            begin
                fbc_next = fbc_reg + CNT_W'(1);
            end

            if (!finished_reg)
            begin
                if (jxmp_pkg::is_payload(phase_reg) && rem_reg != '0)
                begin
                    rem_next = rem_reg - REM_W'(1);
                end

                case (phase_reg)
                    jxmp_pkg::PH_SOI0:
                    begin
                        if (in_byte_reg != jxmp_pkg::MK_PREFIX)
                        begin
                            walk_valid = 1'b1;
                            walk_code  = jxmp_pkg::ST_NOT_JPEG;
                        end
                        else
                        begin
                            phase_next = jxmp_pkg::PH_SOI1;
                        end
                    end
                    jxmp_pkg::PH_SOI1:
                    begin
                        if (in_byte_reg != jxmp_pkg::MK_SOI)
                        begin
                            walk_valid = 1'b1;
                            walk_code  = jxmp_pkg::ST_NOT_JPEG;
                        end
                        else
                        begin
                            phase_next = jxmp_pkg::PH_MK0;
                        end
                    end
                    jxmp_pkg::PH_MK0:
                    begin
                        if (in_byte_reg != jxmp_pkg::MK_PREFIX)
                        begin
                            walk_valid = 1'b1;
                            walk_code  = jxmp_pkg::ST_OK;
                        end
                        else
                        begin
                            phase_next = jxmp_pkg::PH_MK1;
                        end
                    end
                    jxmp_pkg::PH_MK1:
                    begin
                        if (in_byte_reg == jxmp_pkg::MK_SOS)
                        begin
                            walk_valid = 1'b1;
                            walk_code  = jxmp_pkg::ST_OK;
                        end
                        else
                        begin
                            app1_next  = (in_byte_reg == jxmp_pkg::MK_APP1);
                            phase_next = jxmp_pkg::PH_LEN0;
                        end
                    end
                    jxmp_pkg::PH_LEN0:
                    begin
                        rem_next   = {in_byte_reg, 8'h00};
                        phase_next = jxmp_pkg::PH_LEN1;
                    end
                    jxmp_pkg::PH_LEN1:
                    begin
                        // Length field counts its own two bytes
                        if (seg_len < (REM_W+1)'(2))
                        begin
                            walk_valid = 1'b1;
                            walk_code  = jxmp_pkg::ST_BAD_LEN;
                        end
                        else
                        begin
                            rem_next   = REM_W'(seg_len - (REM_W+1)'(2));
                            idx_next   = '0;
                            match_next = app1_reg ? 2'b11 : 2'b00;
                            phase_next = (seg_len != (REM_W+1)'(2)) ? jxmp_pkg::PH_PAY
                                                                     : jxmp_pkg::PH_MK0;
                        end
                    end
                    jxmp_pkg::PH_PAY:
                    begin
                        // Match both signatures side by side
                        if (match_reg != 2'b00)
                        begin
                            if (jxmp_pkg::main_mismatch(idx_reg, in_byte_reg))
                            begin
                                m[0] = 1'b0;
                            end
                            if (jxmp_pkg::ext_mismatch(idx_reg, in_byte_reg))
                            begin
                                m[1] = 1'b0;
                            end
                            match_next = m;
                            if (idx_reg != jxmp_pkg::IDX_MAX)
                            begin
                                idx_next = idx_reg + IDX_W'(1);
                            end
                            if (idx_reg == IDX_W'(jxmp_pkg::SIG_MAIN_LEN - 1) && m[0])
                            begin
                                phase_next = jxmp_pkg::PH_MAIN;
                            end
                            else if (idx_reg == IDX_W'(jxmp_pkg::SIG_EXT_LEN - 1) && m[1])
                            begin
                                phase_next = jxmp_pkg::PH_EXTHDR;
                                idx_next   = '0;
                                shift_next = '0;
                            end
                        end
                    end
                    jxmp_pkg::PH_MAIN:
                    begin
                        data_valid             = 1'b1;
                        data_res.kind          = jxmp_pkg::KIND_MAIN;
                        data_res.out_byte      = in_byte_reg;
                        data_res.segment_start =
                            (idx_reg == IDX_W'(jxmp_pkg::SIG_MAIN_LEN));
                        idx_next = IDX_W'(jxmp_pkg::SIG_MAIN_LEN + 1);
                    end
                    jxmp_pkg::PH_EXTHDR:
                    begin
                        // Skip the GUID, then shift in full length and offset
                        if (idx_reg >= IDX_W'(jxmp_pkg::EXT_GUID_LEN) &&
                            idx_reg <  IDX_W'(jxmp_pkg::EXT_GUID_LEN + 4))
                        begin
                            shift_next = {shift_reg[23:0], in_byte_reg};
                        end
                        else if (idx_reg >= IDX_W'(jxmp_pkg::EXT_GUID_LEN + 4) &&
                                 idx_reg <  IDX_W'(jxmp_pkg::EXT_HDR_LEN))
                        begin
                            chunk_next = {1'b0, chunk_reg[23:0], in_byte_reg};
                        end
                        if (idx_reg == IDX_W'(jxmp_pkg::EXT_GUID_LEN + 3))
                        begin
                            chunk_next = '0;
                        end
                        if (idx_reg == IDX_W'(jxmp_pkg::EXT_HDR_LEN - 1))
                        begin
                            extlen_next = shift_reg;
                            seen_next   = 1'b1;
                            if (chunk_next > {1'b0, shift_reg})
                            begin
                                fault_next = 1'b1;
                            end
                            phase_next = jxmp_pkg::PH_EXTDATA;
                        end
                        if (idx_reg != jxmp_pkg::IDX_MAX)
                        begin
                            idx_next = idx_reg + IDX_W'(1);
                        end
                    end
                    jxmp_pkg::PH_EXTDATA:
                    begin
                        if (chunk_reg >= {1'b0, extlen_reg})
                        begin
                            fault_next = 1'b1;
                        end
                        data_valid                = 1'b1;
                        data_res.kind             = jxmp_pkg::KIND_EXT;
                        data_res.out_byte         = in_byte_reg;
                        data_res.ext_position     = chunk_reg[31:0];
                        data_res.ext_total_length = extlen_reg;
                        chunk_next = chunk_reg + POS_W'(1);
                    end
                    default:
                    begin
                    end
                endcase

                // Leave the segment when its payload is used up
                if (!walk_valid && jxmp_pkg::is_payload(phase_next) && rem_next == '0)
                begin
                    phase_next = jxmp_pkg::PH_MK0;
                end

                if (!walk_valid && in_last_reg)
                begin
                    walk_valid = 1'b1;
                    walk_code  = jxmp_pkg::is_payload(phase_next) ? jxmp_pkg::ST_TRUNCATED
                                                                  : jxmp_pkg::ST_OK;
                end

                // Close the file with a status
                if (walk_valid)
                begin
                    stat_code = walk_code;
                    if (in_last_reg && fbc_reg <= CNT_W'(2))
                    begin
                        stat_code = jxmp_pkg::ST_NOT_JPEG;
                    end
                    if (stat_code == jxmp_pkg::ST_OK && seen_next)
                    begin
                        if (extlen_next == '0)
                        begin
                            stat_code = jxmp_pkg::ST_ZERO_EXT;
                        end
                        else if (fault_next)
                        begin
                            stat_code = jxmp_pkg::ST_OUT_BOUNDS;
                        end
                    end
                    finished_next = 1'b1;
                    phase_next    = jxmp_pkg::PH_DONE;
                end
            end

            // End of file: back to the reset state
            if (in_last_reg)
            begin
                phase_next    = jxmp_pkg::PH_SOI0;
                fbc_next      = '0;
                rem_next      = '0;
                app1_next     = 1'b0;
                idx_next      = '0;
                match_next    = 2'b11;
                shift_next    = '0;
                extlen_next   = '0;
                chunk_next    = '0;
                seen_next     = 1'b0;
                finished_next = 1'b0;
                fault_next    = 1'b0;
            end
        end
    end

    // Pack the results of this byte
    always_comb
    begin
        stat_res             = '0;
        stat_res.kind        = jxmp_pkg::KIND_STATUS;
        stat_res.status      = stat_code;
        stat_res.last_result = 1'b1;
        push                 = '0;
        if (data_valid && walk_valid)
        begin
            push.count  = 2'd2;
            push.first  = data_res;
            push.second = stat_res;
        end
        else if (data_valid)
        begin
            push.count             = 2'd1;
            push.first             = data_res;
            push.first.last_result = 1'b1;
        end
        else if (walk_valid)
        begin
            push.count = 2'd1;
            push.first = stat_res;
        end
    end

    // A byte that yields two results yields a payload byte and then the status
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> push.first.kind != jxmp_pkg::KIND_STATUS &&
                               push.second.kind == jxmp_pkg::KIND_STATUS)
        else $error("two results out of order");

    // The last byte of a file returns the parser to the start
    a_file_reset: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_last_reg |=> phase_reg == jxmp_pkg::PH_SOI0 && !finished_reg)
        else $error("parser not reset after last byte");

    // Once the status is out, the parser sits in the done phase
    a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |-> phase_reg == jxmp_pkg::PH_DONE)
        else $error("finished outside done phase");

endmodule

### src/jxmp_rfifo.sv
module jxmp_rfifo (
    input  logic               clk,
    input  logic               rst_n,
    input  jxmp_pkg::push_t    push,
    output logic               room,
    jxmp_out_if.source         result_ch
);

    localparam int DEPTH = jxmp_pkg::RQ_DEPTH;
    localparam int PTR_W = jxmp_pkg::RQ_PTR_W;
    localparam int CNT_W = jxmp_pkg::RQ_CNT_W;

    jxmp_pkg::result_t mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              pop;
    jxmp_pkg::result_t head;

    assign pop  = result_ch.valid && result_ch.ready;
    assign room = (count_reg <= CNT_W'(DEPTH - 2));

    // Drive the head entry
    assign head                       = mem_reg[rd_ptr_reg];
    assign result_ch.valid            = (count_reg != '0);
    assign result_ch.kind             = head.kind;
    assign result_ch.out_byte         = head.out_byte;
    assign result_ch.segment_start    = head.segment_start;
    assign result_ch.ext_position     = head.ext_position;
    assign result_ch.ext_total_length = head.ext_total_length;
    assign result_ch.status           = head.status;
    assign result_ch.last_result      = head.last_result;

    // Store up to two results per cycle
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_reg + PTR_W'(1)] <= push.second;
        end
    end

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("result queue overflow");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        !room |-> push.count == 2'd0)
        else $error("results pushed without room");

    // Hold the head transaction while the sink stalls
    a_hold_head: assert property (@(posedge clk) disable iff (!rst_n)
        result_ch.valid && !result_ch.ready |=> result_ch.valid && $stable(head))
        else $error("head result changed while stalled");

endmodule

### src/jpeg_xmp_segment_extractor.sv
// Channel    Dir  Payload                                            Accepted when
// byte_ch    in   data_byte, last_byte                               valid && ready
// result_ch  out  kind, out_byte, segment_start, ext_position,       valid && ready
//                 ext_total_length, status, last_result
//
// One byte per cycle while the result queue has room: each byte is parsed
// combinationally between the input register and a four-entry result queue,
// and its results leave one per cycle while result_ch is ready.
// Reset is asynchronous and active low; no clearing pass, byte_ch is ready
// during reset and as soon as it ends.
// byte_ch stalls while a byte waits in the input register and the result
// queue holds more than two results.
module jpeg_xmp_segment_extractor (
    input  logic       clk,
    input  logic       rst_n,
    jxmp_in_if.sink    byte_ch,
    jxmp_out_if.source result_ch
);

    jxmp_pkg::push_t push;
    logic            room;

    jxmp_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_ch (byte_ch),
        .room    (room),
        .push    (push)
    );

    jxmp_rfifo u_rfifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .result_ch (result_ch)
    );

endmodule

### verif/jpeg_xmp_segment_extractor_tb.sv
`timescale 1ns / 100ps

localparam int MAIN_URI_LEN  = 29;
localparam int EXT_URI_LEN   = 35;
localparam int GUID_LEN      = 32;
localparam int EXT_HDR_BYTES = GUID_LEN + 8;

// Namespace URIs with their closing zero byte, first character in the top byte
localparam logic [8*MAIN_URI_LEN-1:0] MAIN_URI =
    232'h68747470_3A2F2F6E_732E6164_6F62652E_636F6D2F_7861702F_312E302F_00;
localparam logic [8*EXT_URI_LEN-1:0] EXT_URI =
    280'h68747470_3A2F2F6E_732E6164_6F62652E_636F6D2F_786D702F_65787465_6E73696F_6E2F00;

function automatic logic [7:0] uri_byte(bit extended, int i);
    if (extended)
    begin
        return EXT_URI[8*(EXT_URI_LEN-1-i) +: 8];
    end
    return MAIN_URI[8*(MAIN_URI_LEN-1-i) +: 8];
endfunction

class xmp_scoreboard;
    jxmp_pkg::result_t pending_results[$];
    int                mismatches;
    int                results_checked;
    int                main_count;
    int                ext_count;
    int                status_count;
    bit [7:0]          status_mask;

    // Parser state of the predicted block
    jxmp_pkg::phase_t  phase;
    int                byte_count;
    int                seg_left;
    bit                in_app1;
    int                sig_pos;
    bit [1:0]          sig_alive;
    bit                fresh_packet;
    logic [31:0]       len_shift;
    logic [31:0]       ext_len;
    logic [63:0]       chunk_pos;
    bit                ext_seen;
    bit                done;
    bit                chunk_fault;

    function new();
        clear_parser();
    endfunction

    function void clear_parser();
        phase        = jxmp_pkg::PH_SOI0;
        byte_count   = 0;
        seg_left     = 0;
        in_app1      = 1'b0;
        sig_pos      = 0;
        sig_alive    = 2'b11;
        fresh_packet = 1'b0;
        len_shift    = '0;
        ext_len      = '0;
        chunk_pos    = '0;
        ext_seen     = 1'b0;
        done         = 1'b0;
        chunk_fault  = 1'b0;
    endfunction

    function int pending();
        return pending_results.size();
    endfunction

    function void emit(logic [1:0] kind, logic [7:0] value, logic start,
                       logic [31:0] pos, logic [31:0] total, logic [2:0] st);
        jxmp_pkg::result_t r;
        r.kind             = kind;
        r.out_byte         = value;
        r.segment_start    = start;
        r.ext_position     = pos;
        r.ext_total_length = total;
        r.status           = st;
        r.last_result      = 1'b0;
        pending_results    = {pending_results, r};
    endfunction

    // Advance the parser by one accepted byte and queue the results it causes
    function void absorb_byte(logic [7:0] b, logic last);
        int         pos_in_file;
        int         first_new;
        int         i;
        int         seg_len;
        bit         ending;
        logic [2:0] st;
        pos_in_file = byte_count;
        first_new   = pending_results.size();
        ending      = 1'b0;
        st          = jxmp_pkg::ST_OK;
        if (byte_count < 4)
        begin
            byte_count++;
        end
        if (!done)
        begin
            if (phase >= jxmp_pkg::PH_PAY && phase <= jxmp_pkg::PH_EXTDATA && seg_left > 0)
            begin
                seg_left--;
            end
            case (phase)
                jxmp_pkg::PH_SOI0:
                begin
                    if (b != jxmp_pkg::MK_PREFIX)
                    begin
                        ending = 1'b1;
                        st     = jxmp_pkg::ST_NOT_JPEG;
                    end
                    else
                    begin
                        phase = jxmp_pkg::PH_SOI1;
                    end
                end
                jxmp_pkg::PH_SOI1:
                begin
                    if (b != jxmp_pkg::MK_SOI)
                    begin
                        ending = 1'b1;
                        st     = jxmp_pkg::ST_NOT_JPEG;
                    end
                    else
                    begin
                        phase = jxmp_pkg::PH_MK0;
                    end
                end
                jxmp_pkg::PH_MK0:
                begin
                    if (b != jxmp_pkg::MK_PREFIX)
                    begin
                        ending = 1'b1;
                    end
                    else
                    begin
                        phase = jxmp_pkg::PH_MK1;
                    end
                end
                jxmp_pkg::PH_MK1:
                begin
                    if (b == jxmp_pkg::MK_SOS)
                    begin
                        ending = 1'b1;
                    end
                    else
                    begin
                        in_app1 = (b == jxmp_pkg::MK_APP1);
                        phase   = jxmp_pkg::PH_LEN0;
                    end
                end
                jxmp_pkg::PH_LEN0:
                begin
                    seg_left = int'(b) << 8;
                    phase    = jxmp_pkg::PH_LEN1;
                end
                jxmp_pkg::PH_LEN1:
                begin
                    seg_len = seg_left + int'(b);
                    if (seg_len < 2)
                    begin
                        ending = 1'b1;
                        st     = jxmp_pkg::ST_BAD_LEN;
                    end
                    else
                    begin
                        seg_left  = seg_len - 2;
                        sig_pos   = 0;
                        sig_alive = in_app1 ? 2'b11 : 2'b00;
                        phase     = (seg_left != 0) ? jxmp_pkg::PH_PAY : jxmp_pkg::PH_MK0;
                    end
                end
                jxmp_pkg::PH_PAY:
                begin
                    // Match both signatures in parallel, drop a candidate on a miss
                    if (sig_alive != 2'b00)
                    begin
                        i = sig_pos;
                        if (i < MAIN_URI_LEN && uri_byte(1'b0, i) != b)
                        begin
                            sig_alive[0] = 1'b0;
                        end
                        if (i < EXT_URI_LEN && uri_byte(1'b1, i) != b)
                        begin
                            sig_alive[1] = 1'b0;
                        end
                        if (sig_pos < 63)
                        begin
                            sig_pos++;
                        end
                        if (i == MAIN_URI_LEN - 1 && sig_alive[0])
                        begin
                            phase        = jxmp_pkg::PH_MAIN;
                            fresh_packet = 1'b1;
                        end
                        else if (i == EXT_URI_LEN - 1 && sig_alive[1])
                        begin
                            phase     = jxmp_pkg::PH_EXTHDR;
                            sig_pos   = 0;
                            len_shift = '0;
                        end
                    end
                end
                jxmp_pkg::PH_MAIN:
                begin
                    emit(jxmp_pkg::KIND_MAIN, b, fresh_packet, '0, '0, jxmp_pkg::ST_OK);
                    fresh_packet = 1'b0;
                end
                jxmp_pkg::PH_EXTHDR:
                begin
                    // GUID is skipped, then full length and chunk offset, big endian
                    i = sig_pos;
                    if (i >= GUID_LEN && i < GUID_LEN + 4)
                    begin
                        len_shift = {len_shift[23:0], b};
                    end
                    else if (i >= GUID_LEN + 4 && i < EXT_HDR_BYTES)
                    begin
                        chunk_pos = {32'b0, chunk_pos[23:0], b};
                    end
                    if (i == GUID_LEN + 3)
                    begin
                        chunk_pos = '0;
                    end
                    if (i == EXT_HDR_BYTES - 1)
                    begin
                        ext_len  = len_shift;
                        ext_seen = 1'b1;
                        if (chunk_pos > {32'b0, ext_len})
                        begin
                            chunk_fault = 1'b1;
                        end
                        phase = jxmp_pkg::PH_EXTDATA;
                    end
                    if (sig_pos < 63)
                    begin
                        sig_pos++;
                    end
                end
                jxmp_pkg::PH_EXTDATA:
                begin
                    if (chunk_pos >= {32'b0, ext_len})
                    begin
                        chunk_fault = 1'b1;
                    end
                    emit(jxmp_pkg::KIND_EXT, b, 1'b0, chunk_pos[31:0], ext_len,
                         jxmp_pkg::ST_OK);
                    chunk_pos++;
                end
                default:
                begin
                end
            endcase
            if (!ending && phase >= jxmp_pkg::PH_PAY && phase <= jxmp_pkg::PH_EXTDATA &&
                seg_left == 0)
            begin
                phase = jxmp_pkg::PH_MK0;
            end
            if (!ending && last)
            begin
                ending = 1'b1;
                st     = (phase >= jxmp_pkg::PH_PAY && phase <= jxmp_pkg::PH_EXTDATA) ?
                         jxmp_pkg::ST_TRUNCATED : jxmp_pkg::ST_OK;
            end
            // A file of at most three bytes is not JPEG; walk errors win, then the extended chunk checks
            if (ending)
            begin
                if (last && pos_in_file <= 2)
                begin
                    st = jxmp_pkg::ST_NOT_JPEG;
                end
                if (st == jxmp_pkg::ST_OK && ext_seen)
                begin
                    if (ext_len == 0)
                    begin
                        st = jxmp_pkg::ST_ZERO_EXT;
                    end
                    else if (chunk_fault)
                    begin
                        st = jxmp_pkg::ST_OUT_BOUNDS;
                    end
                end
                emit(jxmp_pkg::KIND_STATUS, 8'h00, 1'b0, '0, '0, st);
                done  = 1'b1;
                phase = jxmp_pkg::PH_DONE;
            end
        end
        if (pending_results.size() > first_new)
        begin
            pending_results[pending_results.size() - 1].last_result = 1'b1;
        end
        if (last)
        begin
            clear_parser();
        end
    endfunction

    task report(string what);
        mismatches++;
        if (mismatches <= 200)
        begin
            $display("%0t: mismatch: %s", $time, what);
        end
    endtask

    task check_field(string field, logic [31:0] got, logic [31:0] want);
        if (got !== want)
        begin
            report($sformatf("result %0d: %s is %0h, expected %0h",
                             results_checked, field, got, want));
        end
    endtask

    task check_result(jxmp_pkg::result_t got);
        jxmp_pkg::result_t want;
        if (pending_results.size() == 0)
        begin
            report($sformatf("result with none predicted: kind %0d byte %02h status %0d",
                             got.kind, got.out_byte, got.status));
            return;
        end
        want = pending_results.pop_front();
        results_checked++;
        check_field("kind", 32'(got.kind), 32'(want.kind));
        check_field("out_byte", 32'(got.out_byte), 32'(want.out_byte));
        check_field("segment_start", 32'(got.segment_start), 32'(want.segment_start));
        check_field("ext_position", got.ext_position, want.ext_position);
        check_field("ext_total_length", got.ext_total_length, want.ext_total_length);
        check_field("status", 32'(got.status), 32'(want.status));
        check_field("last_result", 32'(got.last_result), 32'(want.last_result));
        if (want.kind == jxmp_pkg::KIND_STATUS)
        begin
            status_count++;
            status_mask[want.status] = 1'b1;
        end
        else if (want.kind == jxmp_pkg::KIND_EXT)
        begin
            ext_count++;
        end
        else
        begin
            main_count++;
        end
    endtask
endclass

module jpeg_xmp_segment_extractor_tb;

    localparam int RANDOM_BYTES   = 950;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 16;

    logic          clk;
    logic          rst_n;
    bit            steady;
    int            idle_cycles;
    int            files_sent;
    int            bytes_sent;
    int            random_start;
    logic [7:0]    file_q[$];
    logic [7:0]    seg_q[$];
    xmp_scoreboard sb = new();

    jxmp_in_if  byte_ch();
    jxmp_out_if result_ch();

    jpeg_xmp_segment_extractor DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_ch   (byte_ch),
        .result_ch (result_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Stall the result side at random, never during the steady stretch
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            result_ch.ready <= steady || ($urandom_range(99) >= 35);
        end
    end

    // Check every accepted result against the oldest prediction
    always @(posedge clk)
    begin : result_monitor
        jxmp_pkg::result_t seen;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            seen.kind             = result_ch.kind;
            seen.out_byte         = result_ch.out_byte;
            seen.segment_start    = result_ch.segment_start;
            seen.ext_position     = result_ch.ext_position;
            seen.ext_total_length = result_ch.ext_total_length;
            seen.status           = result_ch.status;
            seen.last_result      = result_ch.last_result;
            sb.check_result(seen);
        end
    end

    // End the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (byte_ch.valid && byte_ch.ready) ||
            (result_ch.valid && result_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", idle_cycles);
            $display("TB_ERROR");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Append one byte to the file or to the segment under construction
    task automatic add_to_file(logic [7:0] v);
        file_q = {file_q, v};
    endtask

    task automatic add_to_segment(logic [7:0] v);
        seg_q = {seg_q, v};
    endtask

    // Send file_q one byte per transaction, marking the final byte
    task automatic send_file();
        for (int i = 0; i < file_q.size(); i++)
        begin
            while (!steady && $urandom_range(99) < 35)
            begin
                byte_ch.valid <= 1'b0;
                @(posedge clk);
            end
            byte_ch.valid     <= 1'b1;
            byte_ch.data_byte <= file_q[i];
            byte_ch.last_byte <= (i == file_q.size() - 1);
            @(posedge clk);
            while (!byte_ch.ready)
            begin
                @(posedge clk);
            end
            sb.absorb_byte(file_q[i], i == file_q.size() - 1);
            bytes_sent++;
        end
        files_sent++;
    endtask

    // Hold the sender until every predicted result has come out
    task automatic wait_for_drain();
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic push_word(logic [31:0] w);
        for (int s = 24; s >= 0; s -= 8)
        begin
            add_to_segment(w[s +: 8]);
        end
    endtask

    // Build one file, mostly well formed with random content, and send it
    task automatic random_file();
        int          pick;
        int          kind_pick;
        int          n;
        int          seg_len;
        bit          sel;
        logic [7:0]  marker;
        logic [31:0] full_len;
        logic [31:0] offset;
        file_q.delete();
        if ($urandom_range(99) < 8)
        begin
            // Noise: a few random bytes
            repeat ($urandom_range(1, 8))
            begin
                add_to_file(8'($urandom));
            end
        end
        else
        begin
            add_to_file(jxmp_pkg::MK_PREFIX);
            add_to_file(jxmp_pkg::MK_SOI);
            if ($urandom_range(99) < 4)
            begin
                file_q[$urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
            end
            repeat ($urandom_range(1, 3))
            begin
                seg_q.delete();
                marker    = jxmp_pkg::MK_APP1;
                kind_pick = $urandom_range(99);
                if (kind_pick < 30)
                begin
                    // Main packet: signature, then a few packet bytes
                    for (int i = 0; i < MAIN_URI_LEN; i++)
                    begin
                        add_to_segment(uri_byte(1'b0, i));
                    end
                    repeat ($urandom_range(0, 6))
                    begin
                        add_to_segment(8'($urandom));
                    end
                end
                else if (kind_pick < 70)
                begin
                    for (int i = 0; i < EXT_URI_LEN; i++)
                    begin
                        add_to_segment(uri_byte(1'b1, i));
                    end
                    if (kind_pick < 60)
                    begin
                        // Extended chunk: GUID, full length, offset, data
                        repeat (GUID_LEN)
                        begin
                            add_to_segment(8'($urandom));
                        end
                        n    = $urandom_range(0, 8);
                        pick = $urandom_range(99);
                        if (pick < 50)
                            offset = '0;
                        else if (pick < 80)
                            offset = $urandom_range(0, 20);
                        else if (pick < 92)
                            offset = $urandom;
                        else
                            offset = '1;
                        pick = $urandom_range(99);
                        if (pick < 12)
                            full_len = '0;
                        else if (pick < 55)
                            full_len = offset + n + $urandom_range(0, 4);
                        else if (pick < 75)
                            full_len = offset + $urandom_range(0, n);
                        else if (pick < 90)
                            full_len = $urandom;
                        else
                            full_len = '1;
                        push_word(full_len);
                        push_word(offset);
                        repeat (n)
                        begin
                            add_to_segment(8'($urandom));
                        end
                    end
                    else
                    begin
                        // Extended header cut short: segment gets skipped
                        repeat ($urandom_range(0, EXT_HDR_BYTES - 1))
                        begin
                            add_to_segment(8'($urandom));
                        end
                    end
                end
                else
                begin
                    // Other segment, sometimes opening like a signature
                    marker = $urandom_range(0, 1) ? jxmp_pkg::MK_APP1 : 8'($urandom);
                    sel    = $urandom_range(0, 1);
                    n      = ($urandom_range(99) < 40) ?
                             $urandom_range(0, sel ? EXT_URI_LEN - 1 : MAIN_URI_LEN - 1) : 0;
                    for (int i = 0; i < n; i++)
                    begin
                        add_to_segment(uri_byte(sel, i));
                    end
                    repeat ($urandom_range(0, 6))
                    begin
                        add_to_segment(8'($urandom));
                    end
                end
                // Damage a byte now and then
                if ($urandom_range(99) < 6 && seg_q.size() > 0)
                begin
                    seg_q[$urandom_range(0, seg_q.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
                end
                seg_len = seg_q.size() + 2;
                pick    = $urandom_range(99);
                if (pick < 3)
                    seg_len = $urandom_range(0, 1);
                else if (pick < 6)
                    seg_len = $urandom_range(0, 65535);
                else if (pick < 12)
                    seg_len = seg_len + int'($urandom_range(0, 4)) - 2;
                add_to_file(jxmp_pkg::MK_PREFIX);
                add_to_file(marker);
                add_to_file(8'(seg_len >> 8));
                add_to_file(8'(seg_len));
                foreach (seg_q[k])
                begin
                    add_to_file(seg_q[k]);
                end
            end
            pick = $urandom_range(99);
            if (pick < 40)
            begin
                // Scan start; trailing bytes are ignored
                add_to_file(jxmp_pkg::MK_PREFIX);
                add_to_file(jxmp_pkg::MK_SOS);
                repeat ($urandom_range(0, 3))
                begin
                    add_to_file(8'($urandom));
                end
            end
            else if (pick < 50)
            begin
                add_to_file(8'($urandom_range(0, 254)));
            end
            else if (pick < 65)
            begin
                file_q = file_q[0:$urandom_range(0, file_q.size() - 1)];
            end
        end
        send_file();
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        byte_ch.valid     <= 1'b0;
        byte_ch.data_byte <= 8'h00;
        byte_ch.last_byte <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed files: short, bad SOI, scan start, bad length, cut-off cases
        for (int d = 0; d < 6; d++)
        begin
            case (d)
                0: file_q = '{8'h00};
                1: file_q = '{jxmp_pkg::MK_PREFIX, jxmp_pkg::MK_SOI, jxmp_pkg::MK_PREFIX};
                2: file_q = '{jxmp_pkg::MK_PREFIX, jxmp_pkg::MK_SOI, jxmp_pkg::MK_PREFIX,
                              jxmp_pkg::MK_SOS, 8'hFF};
                3: file_q = '{jxmp_pkg::MK_PREFIX, jxmp_pkg::MK_SOI, jxmp_pkg::MK_PREFIX,
                              8'hE0, 8'h00, 8'h01};
                4: file_q = '{jxmp_pkg::MK_PREFIX, jxmp_pkg::MK_SOI, jxmp_pkg::MK_PREFIX,
                              8'hE0, 8'h00, 8'h04, 8'hAA};
                default: file_q = '{jxmp_pkg::MK_PREFIX, jxmp_pkg::MK_SOI,
                                    jxmp_pkg::MK_PREFIX, jxmp_pkg::MK_APP1};
            endcase
            send_file();
        end
        wait_for_drain();

        // Random files, with a stretch of full throughput in the middle
        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES)
        begin
            steady <= (bytes_sent - random_start >= 300) && (bytes_sent - random_start < 500);
            random_file();
            if ($urandom_range(9) == 0)
            begin
                wait_for_drain();
            end
        end

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Ran %0d files, %0d bytes: %0d main, %0d extended, %0d status results checked",
                 files_sent, bytes_sent, sb.main_count, sb.ext_count, sb.status_count);
        $display("Status codes reached (bit per code): %06b; mismatches: %0d",
                 sb.status_mask[5:0], sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### files.f
src/jxmp_pkg.sv
src/jxmp_if.sv
src/jxmp_core.sv
src/jxmp_rfifo.sv
src/jpeg_xmp_segment_extractor.sv
verif/jpeg_xmp_segment_extractor_tb.sv
